>>> src/erbm_pkg.sv
package erbm_pkg;

    // Register and field widths
    localparam int CFG_W          = 13;
    localparam int CFG_INDEX_W    = 1;
    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int COORD_W        = 12;
    localparam int GRAY_W         = 8;
    localparam int STEP_W         = 8;
    localparam int BLUR_W         = 8;
    localparam int SUM_W          = 31;
    localparam int CNT_W          = 24;
    localparam int M_TDATA_W      = 96;
    localparam int QUEUE_DEPTH    = 4;
    localparam int DIV_STEPS      = STEP_W;

    localparam logic [CFG_W-1:0] DIM_RESET = 13'd4096;
    localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    // Result kinds
    typedef enum logic {
        KIND_RUN     = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    // Fixed part of a queued job; the run length travels beside it
    typedef struct packed {
        kind_t               kind;
        logic [COORD_W-1:0]  column;
        logic [COORD_W-1:0]  row;
        logic [GRAY_W-1:0]   diff;
    } job_head_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_EMIT
    } back_state_t;

    // Blur byte of a step: 255 * (1 - (k/255 - 0.01)/0.03)^5 clamped and floored,
    // worked out exactly for the few steps that fall inside the ramp
    function automatic logic [BLUR_W-1:0] blur_of_step(input logic [STEP_W-1:0] k);
        logic [BLUR_W-1:0] b;
        case (k)
            8'd0, 8'd1, 8'd2: b = 8'd255;
            8'd3:             b = 8'd188;
            8'd4:             b = 8'd89;
            8'd5:             b = 8'd37;
            8'd6:             b = 8'd12;
            8'd7:             b = 8'd3;
            default:          b = 8'd1;
        endcase
        return b;
    endfunction

endpackage

>>> src/erbm_fifo.sv
module erbm_fifo
    import erbm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output queue_status_t    status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    fill_reg, fill_next;

    assign status.full  = (fill_reg == CW'(DEPTH));
    assign status.empty = (fill_reg == '0);
    assign rd_data      = slot_reg[rd_ptr_reg];

    // Pointer and fill update, pointers wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> src/erbm_front.sv
module erbm_front
    import erbm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int LEN_W     = $clog2(MAX_WIDTH)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [GRAY_W-1:0]   s_tdata,      // gray
    input  logic [0:0]          s_tuser,      // edge_mask
    input  logic [CFG_W-1:0]    image_width,
    input  logic [CFG_W-1:0]    image_height,
    input  queue_status_t       q_status,
    output logic                push,
    output job_head_t           job_head,
    output logic [LEN_W-1:0]    job_len
);

    localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int HW = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;
    localparam int RW = $clog2(MAX_HEIGHT);

    logic [LEN_W-1:0]  col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic              in_run_reg, in_run_next;
    logic [GRAY_W-1:0] gray_before_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [GRAY_W-1:0] prev_gray_reg;

    logic [WW-1:0]     w_raw, w_eff, col_w;
    logic [HW-1:0]     h_raw, h_eff, row_h;
    logic              accept, masked;
    logic              row_end, frame_end, interior, active;
    logic              close_run, start_run, extend_run;
    logic [LEN_W-1:0]  col_sel;

    // Effective frame size, raised to at least 3 and clamped to what the counters can hold
    always_comb
    begin
        w_raw = WW'(image_width);
        h_raw = HW'(image_height);
        if (w_raw < WW'(3))
            w_eff = WW'(3);
        else if (w_raw > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = w_raw;
        if (h_raw < HW'(3))
            h_eff = HW'(3);
        else if (h_raw > HW'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = h_raw;
    end

    // Pixel classification
    assign s_tready   = !q_status.full;
    assign accept     = s_tvalid && s_tready;
    assign masked     = s_tuser[0];
    assign col_w      = WW'(col_reg);
    assign row_h      = HW'(row_reg);
    assign row_end    = (col_w >= w_eff - WW'(1));
    assign frame_end  = row_end && (row_h >= h_eff - HW'(1));
    assign interior   = (row_h >= HW'(1)) && (row_h <= h_eff - HW'(2));
    assign active     = interior && (col_reg != '0);
    assign close_run  = accept && active && in_run_reg && masked;
    assign extend_run = accept && active && in_run_reg && !masked;
    assign start_run  = accept && active && !in_run_reg && !masked
                        && (col_w <= w_eff - WW'(2));

    // Job towards the back end: a closed run or the frame summary
    assign push    = close_run || (accept && frame_end);
    assign col_sel = frame_end ? col_reg : col_reg - LEN_W'(1);
    assign job_len = len_reg;

    always_comb
    begin
        job_head.kind   = frame_end ? KIND_SUMMARY : KIND_RUN;
        job_head.column = COORD_W'(col_sel);
        job_head.row    = COORD_W'(row_reg);
        job_head.diff   = (s_tdata > gray_before_reg) ? s_tdata - gray_before_reg
                                                      : gray_before_reg - s_tdata;
    end

    // Counters and run flag
    always_comb
    begin
        col_next    = col_reg;
        row_next    = row_reg;
        in_run_next = in_run_reg;
        if (accept)
        begin
            if (close_run)
                in_run_next = 1'b0;
            else if (start_run)
                in_run_next = 1'b1;
            if (row_end)
            begin
                in_run_next = 1'b0;
                col_next    = '0;
                row_next    = frame_end ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            in_run_reg <= 1'b0;
        end
        else
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            in_run_reg <= in_run_next;
        end
    end

    // Run payload; each is written before it is first read
    always_ff @(posedge clk)
    begin
        if (accept)
            prev_gray_reg <= s_tdata;
        if (start_run)
        begin
            gray_before_reg <= prev_gray_reg;
            len_reg         <= LEN_W'(1);
        end
        else if (extend_run)
        begin
            len_reg <= len_reg + LEN_W'(1);
        end
    end

endmodule

>>> src/erbm_back.sv
module erbm_back
    import erbm_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    localparam int LEN_W    = $clog2(MAX_WIDTH)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  queue_status_t        q_status,
    input  job_head_t            job_head,
    input  logic [LEN_W-1:0]     job_len,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // column, row, blur_level, slope_step,
                                           // slope_sum, run_count, one zero bit
    output logic [0:0]           m_tuser   // kind
);

    localparam int CMPW  = (LEN_W > STEP_W + 1) ? LEN_W : STEP_W + 1;
    localparam int STEPC = $clog2(DIV_STEPS);

    back_state_t          state_reg, state_next;
    job_head_t            head_reg;
    logic [LEN_W-1:0]     divisor_reg;
    logic [STEP_W-1:0]    rem_reg, rem_next;
    logic [STEP_W-1:0]    quo_reg, quo_next;
    logic [STEPC-1:0]     step_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    kind_t                out_kind_reg;

    logic                 out_free, load;
    logic [CMPW-1:0]      trial, div_c;
    logic [SUM_W-1:0]     sum_step;

    assign out_free = !out_valid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                    state_next = (job_head.kind == KIND_SUMMARY) ? B_EMIT : B_DIV;
            end
            B_DIV:
            begin
                if (step_reg == '0)
                    state_next = B_EMIT;
            end
            B_EMIT:
            begin
                if (out_free)
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        pop  = 1'b0;
        load = 1'b0;
        case (state_reg)
            B_IDLE:  pop  = !q_status.empty;
            B_EMIT:  load = out_free;
            default: ;
        endcase
    end

    // One restoring division step: shift in a dividend bit, subtract if it fits
    always_comb
    begin
        trial = CMPW'({rem_reg, quo_reg[STEP_W-1]});
        div_c = CMPW'(divisor_reg);
        if (trial >= div_c)
        begin
            rem_next = STEP_W'(trial - div_c);
            quo_next = {quo_reg[STEP_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = STEP_W'(trial);
            quo_next = {quo_reg[STEP_W-2:0], 1'b0};
        end
    end

    // Saturating add of the step to the frame sum
    assign sum_step = ((SUM_MAX - sum_reg) < SUM_W'(quo_reg)) ? SUM_MAX
                                                                : sum_reg + SUM_W'(quo_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
                step_reg <= STEPC'(DIV_STEPS - 1);
            else if (state_reg == B_DIV)
                step_reg <= step_reg - STEPC'(1);

            if (load)
            begin
                out_valid_reg <= 1'b1;
                if (head_reg.kind == KIND_SUMMARY)
                begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_step;
                    if (cnt_reg != CNT_MAX)
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Job capture, divider datapath and output beat
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            head_reg    <= job_head;
            divisor_reg <= job_len;
            rem_reg     <= '0;
            quo_reg     <= job_head.diff;
        end
        else if (state_reg == B_DIV)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end

        if (load)
        begin
            out_kind_reg <= head_reg.kind;
            if (head_reg.kind == KIND_SUMMARY)
                out_data_reg <= {1'b0, cnt_reg, sum_reg, {STEP_W{1'b0}},
                                 {BLUR_W{1'b0}}, head_reg.row, head_reg.column};
            else
                out_data_reg <= {1'b0, {CNT_W{1'b0}}, {SUM_W{1'b0}}, quo_reg,
                                 blur_of_step(quo_reg), head_reg.row, head_reg.column};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule

>>> src/edge_run_blur_measure.sv
// Edge run blur measure. Pixels come in raster order, one beat each, with the
// gray byte in s_tdata and the edge-mask bit in s_tuser. In interior rows every
// run of unmasked pixels starting at column 1 or later and closed by a masked
// pixel gives one run beat (kind 0) carrying the column of its last pixel, the
// row, the integer gray step per pixel and a blur byte; runs that reach the row
// end are dropped. The frame's last pixel gives one summary beat (kind 1) with
// the sum of steps and the run count. The front end takes one pixel per cycle
// while its four-entry job queue has room; the back end takes one job at a
// time, works a run job through the bit-serial step divider and then emits
// it, emits a summary straight after its fetch, and lets any output beat wait
// on m_tready. Pixels therefore stall when runs close faster than the back end
// retires them for longer than the queue can absorb, or while the receiver
// holds result beats back. Frame size is set through cfg_we/cfg_index/cfg_data
// and is clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT.
module edge_run_blur_measure
    import erbm_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [GRAY_W-1:0]      s_tdata,    // gray
    input  logic [0:0]             s_tuser,    // edge_mask
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,    // column, row, blur_level, slope_step,
                                               // slope_sum, run_count, one zero bit
    output logic [0:0]             m_tuser,    // kind
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    localparam int LEN_W = $clog2(MAX_WIDTH);
    localparam int JOB_W = $bits(job_head_t) + LEN_W;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    queue_status_t    q_status;
    logic             push, pop;
    job_head_t        wr_head, rd_head;
    logic [LEN_W-1:0] wr_len, rd_len;
    logic [JOB_W-1:0] rd_job;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    erbm_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .image_width  (width_reg),
        .image_height (height_reg),
        .q_status     (q_status),
        .push         (push),
        .job_head     (wr_head),
        .job_len      (wr_len)
    );

    erbm_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data ({wr_len, wr_head}),
        .pop     (pop),
        .rd_data (rd_job),
        .status  (q_status)
    );

    assign rd_head = job_head_t'(rd_job[$bits(job_head_t)-1:0]);
    assign rd_len  = rd_job[JOB_W-1:$bits(job_head_t)];

    erbm_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .job_head (rd_head),
        .job_len  (rd_len),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Queue never written when full nor read when empty
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("job queue read while empty");

    // A summary carries no step or blur, a run result no frame totals
    a_summary_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[0] == KIND_SUMMARY)) |-> (m_tdata[39:24] == '0))
        else $error("summary beat with step or blur set");

    a_run_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[0] == KIND_RUN)) |-> (m_tdata[95:40] == '0))
        else $error("run beat with frame totals set");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import erbm_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_PHASE   = 7;
    localparam int SETTLE_LEN   = 20;
    localparam int TAIL_LEN     = 40;
    localparam int QUIET_LIMIT  = 3000;

    // One result beat, split into its fields
    typedef struct packed {
        kind_t              kind;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic [BLUR_W-1:0]  blur;
        logic [STEP_W-1:0]  step;
        logic [SUM_W-1:0]   sum;
        logic [CNT_W-1:0]   count;
    } blur_result_t;

    // Directed pixel; a result is typed in only where it is obvious
    typedef struct packed {
        logic [GRAY_W-1:0] gray;
        logic              mask;
        logic              typed;
        blur_result_t      res;
    } pixel_row_t;

    // Frame geometry for one stretch of random pixels
    typedef struct {
        logic [CFG_W-1:0] wv;
        logic [CFG_W-1:0] hv;
        int               pixels;
        bit               to_frame_end;
        bit               calm;
    } phase_t;

    localparam blur_result_t NONE = '0;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [GRAY_W-1:0]      s_tdata = '0;
    logic [0:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_we = 1'b0;
    cfg_index_t             cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]       cfg_data = '0;

    // Three 3x3 frames: a measured run, a run refused at the last column,
    // a run lost at the row end
    pixel_row_t directed_rows [27] = '{
        '{8'd10,  1'b1, 1'b0, NONE},
        '{8'd20,  1'b0, 1'b0, NONE},
        '{8'd30,  1'b0, 1'b0, NONE},
        '{8'd200, 1'b0, 1'b0, NONE},
        '{8'd0,   1'b0, 1'b0, NONE},
        '{8'd0,   1'b1, 1'b1, '{KIND_RUN, 12'd1, 12'd1, 8'd1, 8'd200, 31'd0, 24'd0}},
        '{8'd0,   1'b0, 1'b0, NONE},
        '{8'd255, 1'b0, 1'b0, NONE},
        '{8'd255, 1'b1, 1'b1, '{KIND_SUMMARY, 12'd2, 12'd2, 8'd0, 8'd0, 31'd200, 24'd1}},
        '{8'd255, 1'b0, 1'b0, NONE},
        '{8'd0,   1'b1, 1'b0, NONE},
        '{8'd128, 1'b0, 1'b0, NONE},
        '{8'd5,   1'b1, 1'b0, NONE},
        '{8'd6,   1'b1, 1'b0, NONE},
        '{8'd7,   1'b0, 1'b0, NONE},
        '{8'd9,   1'b1, 1'b0, NONE},
        '{8'd1,   1'b0, 1'b0, NONE},
        '{8'd0,   1'b0, 1'b1, '{KIND_SUMMARY, 12'd2, 12'd2, 8'd0, 8'd0, 31'd0, 24'd0}},
        '{8'd0,   1'b0, 1'b0, NONE},
        '{8'd0,   1'b0, 1'b0, NONE},
        '{8'd0,   1'b0, 1'b0, NONE},
        '{8'd5,   1'b0, 1'b0, NONE},
        '{8'd6,   1'b0, 1'b0, NONE},
        '{8'd7,   1'b0, 1'b0, NONE},
        '{8'd1,   1'b1, 1'b0, NONE},
        '{8'd1,   1'b1, 1'b0, NONE},
        '{8'd77,  1'b1, 1'b1, '{KIND_SUMMARY, 12'd2, 12'd2, 8'd0, 8'd0, 31'd0, 24'd0}}
    };

    // A short stretch of an over-range width first, then small frames; the
    // first and sixth stretches stop mid-frame so the next geometry lands part
    // way through them
    phase_t phases [9] = '{
        '{13'd8191, 13'd3,    40,  1'b0, 1'b0},
        '{13'd5,    13'd4,    120, 1'b1, 1'b0},
        '{13'd3,    13'd7,    100, 1'b1, 1'b0},
        '{13'd16,   13'd6,    96,  1'b1, 1'b1},
        '{13'd7,    13'd3,    60,  1'b1, 1'b0},
        '{13'd6,    13'd8191, 20,  1'b0, 1'b0},
        '{13'd4,    13'd5,    50,  1'b1, 1'b0},
        '{13'd40,   13'd9,    360, 1'b1, 1'b0},
        '{13'd1,    13'd1,    40,  1'b1, 1'b0}
    };

    // Predictor state
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic [COORD_W-1:0] pix_col;
    logic [COORD_W-1:0] pix_row;
    logic               run_open;
    logic [GRAY_W-1:0]  gray_left_of_run;
    logic [31:0]        run_pixels;
    logic [GRAY_W-1:0]  last_gray;
    logic [SUM_W-1:0]   step_total;
    logic [CNT_W-1:0]   runs_total;

    blur_result_t pending_results [$];

    int idle_pct = 38;
    int errors = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit hold_req = 1'b0;
    int quiet = 0;
    int run_left = 0;
    int walk_gray = 128;

    edge_run_blur_measure dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int dim_in_range(input int v, input int hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // 255 * ((51 - 5k) / 38.25)^5, floored, in integers
    function automatic logic [BLUR_W-1:0] blur_for_step(input int k);
        longint unsigned t;
        longint unsigned p;
        if (k <= 2)
            return 8'd255;
        if (k >= 11)
            return 8'd1;
        t = 4 * (51 - 5 * k);
        p = (t * t * t * t * t * 255) / (153 * 153 * 153 * 153 * 153);
        return (p < 1) ? 8'd1 : BLUR_W'(p);
    endfunction

    // Advance the predicted pixel state by one beat; returns 1 with a result
    function automatic bit measure_pixel(input logic [GRAY_W-1:0] g, input logic m,
                                         output blur_result_t res);
        int  w;
        int  h;
        int  c;
        int  r;
        int  diff;
        int  k;
        bit  row_end;
        bit  frame_end;
        bit  interior;
        bit  found;
        w = dim_in_range(int'(width_reg), DEF_MAX_WIDTH);
        h = dim_in_range(int'(height_reg), DEF_MAX_HEIGHT);
        c = int'(pix_col);
        r = int'(pix_row);
        row_end = c >= w - 1;
        frame_end = row_end && r >= h - 1;
        interior = r >= 1 && r <= h - 2;
        res = '0;
        found = 1'b0;

        if (interior && c >= 1)
        begin
            if (run_open)
            begin
                if (m)
                begin
                    diff = (g > gray_left_of_run) ? int'(g - gray_left_of_run)
                                                  : int'(gray_left_of_run - g);
                    k = (run_pixels != 0) ? int'(32'(diff) / run_pixels) : 0;
                    res.kind = KIND_RUN;
                    res.column = COORD_W'(c - 1);
                    res.row = COORD_W'(r);
                    res.blur = blur_for_step(k);
                    res.step = STEP_W'(k);
                    found = 1'b1;
                    if (32'(SUM_MAX) - 32'(step_total) < 32'(k))
                        step_total = SUM_MAX;
                    else
                        step_total = step_total + SUM_W'(k);
                    if (runs_total != CNT_MAX)
                        runs_total = runs_total + 1'b1;
                    run_open = 1'b0;
                end
                else if (run_pixels != 32'hFFFF_FFFF)
                    run_pixels = run_pixels + 1;
            end
            else if (!m && c <= w - 2)
            begin
                run_open = 1'b1;
                gray_left_of_run = last_gray;
                run_pixels = 1;
            end
        end

        last_gray = g;

        if (row_end)
        begin
            run_open = 1'b0;
            pix_col = '0;
            if (frame_end)
            begin
                res.kind = KIND_SUMMARY;
                res.column = COORD_W'(c);
                res.row = COORD_W'(r);
                res.blur = '0;
                res.step = '0;
                res.sum = step_total;
                res.count = runs_total;
                found = 1'b1;
                step_total = '0;
                runs_total = '0;
                pix_row = '0;
            end
            else
                pix_row = COORD_W'(r + 1);
        end
        else
            pix_col = COORD_W'(c + 1);
        return found;
    endfunction

    task automatic send_pixel(input logic [GRAY_W-1:0] g, input logic m);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= g;
        s_tuser <= m;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Mostly masked gaps and short unmasked runs over a wandering gray level
    task automatic next_pixel(output logic [GRAY_W-1:0] g, output logic m);
        int r;
        int tmp;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            g = GRAY_W'($urandom);
            m = 1'($urandom);
        end
        else
        begin
            if (run_left != 0)
            begin
                m = 1'b0;
                run_left--;
            end
            else
            begin
                m = 1'b1;
                if ($urandom_range(0, 99) < 75)
                    run_left = $urandom_range(1, 6);
            end
            if ($urandom_range(0, 3) == 0)
                walk_gray = $urandom_range(0, 255);
            else
            begin
                tmp = walk_gray + int'($urandom_range(0, 40)) - 20;
                walk_gray = (tmp < 0) ? 0 : (tmp > 255) ? 255 : tmp;
            end
            g = GRAY_W'(walk_gray);
        end
    endtask

    // Both registers back to back, write enable held across the pair
    task automatic write_dims(input logic [CFG_W-1:0] wv, input logic [CFG_W-1:0] hv);
        cfg_we <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_data <= wv;
        @(posedge clk);
        width_reg = wv;
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_data <= hv;
        @(posedge clk);
        height_reg = hv;
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_LEN) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Stimulus
    initial
    begin
        blur_result_t res;
        logic [GRAY_W-1:0] g;
        logic m;
        int n;

        width_reg = DIM_RESET;
        height_reg = DIM_RESET;
        pix_col = '0;
        pix_row = '0;
        run_open = 1'b0;
        gray_left_of_run = '0;
        run_pixels = 0;
        last_gray = '0;
        step_total = '0;
        runs_total = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both registers below range, so 3x3
        write_dims(13'd0, 13'd2);
        foreach (directed_rows[i])
        begin
            send_pixel(directed_rows[i].gray, directed_rows[i].mask);
            if (measure_pixel(directed_rows[i].gray, directed_rows[i].mask, res)
                && !directed_rows[i].typed)
                pending_results.push_back(res);
            if (directed_rows[i].typed)
                pending_results.push_back(directed_rows[i].res);
        end

        foreach (phases[p])
        begin
            settle();
            write_dims(phases[p].wv, phases[p].hv);
            idle_pct = phases[p].calm ? 0 : 38;
            // Dense runs in this frame, so the long hold-off fills the block
            if (p == HOLD_PHASE)
                hold_req = 1'b1;
            for (n = 0;
                 n < phases[p].pixels ||
                 (phases[p].to_frame_end && (pix_col != 0 || pix_row != 0));
                 n++)
            begin
                next_pixel(g, m);
                send_pixel(g, m);
                if (measure_pixel(g, m, res))
                    pending_results.push_back(res);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_LEN) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // Receiver: random back-pressure plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && hold_req)
        begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= idle_pct);
    end

    // Result check against the oldest expectation
    always @(posedge clk)
    begin
        blur_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none actual %0h %0h",
                         $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", want.kind, m_tuser[0]);
                check_field("column", want.column, m_tdata[11:0]);
                check_field("row", want.row, m_tdata[23:12]);
                check_field("blur_level", want.blur, m_tdata[31:24]);
                check_field("slope_step", want.step, m_tdata[39:32]);
                check_field("slope_sum", want.sum, m_tdata[70:40]);
                check_field("run_count", want.count, m_tdata[94:71]);
                check_field("pad", 32'd0, m_tdata[M_TDATA_W-1]);
            end
        end
    end

    // Watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == QUIET_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

endmodule

>>> files.f
src/erbm_pkg.sv
src/erbm_fifo.sv
src/erbm_front.sv
src/erbm_back.sv
src/edge_run_blur_measure.sv
tb/tb.sv
